FILE: rtl/t0apc_pkg.sv
// Package for the T=0 procedure controller: codes, item and burst types,
// and the status word mapping. Depends on nothing.
package t0apc_pkg;

   // Input modes.
   localparam logic [1:0] MODE_START = 2'd0;
   localparam logic [1:0] MODE_CARD  = 2'd1;
   localparam logic [1:0] MODE_HOST  = 2'd2;

   // Result kinds.
   localparam logic [1:0] KIND_TO_CARD = 2'd0;
   localparam logic [1:0] KIND_TO_HOST = 2'd1;
   localparam logic [1:0] KIND_STATUS  = 2'd2;

   // Final status codes.
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_BAD_CMD  = 3'd1;
   localparam logic [2:0] ST_BAD_INS  = 3'd2;
   localparam logic [2:0] ST_BAD_P1P2 = 3'd3;
   localparam logic [2:0] ST_BAD_P3   = 3'd4;
   localparam logic [2:0] ST_UNKNOWN  = 3'd5;
   localparam logic [2:0] ST_BAD_PROC = 3'd6;

   // Controller phases.
   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_PROC = 2'd1;
   localparam logic [1:0] PH_SW2  = 2'd2;
   localparam logic [1:0] PH_MOVE = 2'd3;

   // Special byte values.
   localparam logic [7:0] CLA_INVALID = 8'hFF;
   localparam logic [7:0] PROC_NULL   = 8'h60;
   localparam logic [7:0] SW1_OK      = 8'h90;
   localparam logic [7:0] SW1_BAD_CMD = 8'h6E;
   localparam logic [7:0] SW1_BAD_INS = 8'h6D;
   localparam logic [7:0] SW1_BAD_P12 = 8'h6B;
   localparam logic [7:0] SW1_BAD_P3  = 8'h67;
   localparam logic [7:0] SW1_UNKNOWN = 8'h6F;
   localparam logic [3:0] NIB_SW_6    = 4'h6;
   localparam logic [3:0] NIB_SW_9    = 4'h9;
   localparam logic [8:0] FULL_LENGTH = 9'd256;

   // A burst holds at most the five header bytes.
   localparam int BURST_MAX = 5;
   localparam int CNT_W     = $clog2(BURST_MAX + 1);

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] cla;
      logic [7:0] ins;
      logic [7:0] p1;
      logic [7:0] p2;
      logic [7:0] p3;
      logic       write_flag;
      logic [7:0] data_byte;
   } item_type;

   typedef struct packed {
      logic [CNT_W-1:0]                count;
      logic [1:0]                      kind;
      logic [BURST_MAX-1:0][7:0]       bytes;
      logic [2:0]                      status;
      logic [7:0]                      sw1;
      logic [7:0]                      sw2;
   } burst_type;

   function automatic logic [2:0] map_sw1(input logic [7:0] s1);
      logic [2:0] st;
      case (s1)
         SW1_OK:      st = ST_OK;
         SW1_BAD_CMD: st = ST_BAD_CMD;
         SW1_BAD_INS: st = ST_BAD_INS;
         SW1_BAD_P12: st = ST_BAD_P1P2;
         SW1_BAD_P3:  st = ST_BAD_P3;
         SW1_UNKNOWN: st = ST_UNKNOWN;
         default:     st = ST_BAD_PROC;
      endcase
      return st;
   endfunction

   function automatic logic is_sw_nibble(input logic [7:0] b);
      return (b[7:4] == NIB_SW_6) || (b[7:4] == NIB_SW_9);
   endfunction

endpackage

FILE: rtl/t0apc_if.sv
// Valid/ready channel interfaces for the request and response words.
// Depends on nothing.
interface t0apc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic [7:0] cla;
   logic [7:0] ins;
   logic [7:0] p1;
   logic [7:0] p2;
   logic [7:0] p3;
   logic       write_flag;
   logic [7:0] data_byte;
   modport source (output valid, mode, cla, ins, p1, p2, p3, write_flag, data_byte,
                   input ready);
   modport sink   (input valid, mode, cla, ins, p1, p2, p3, write_flag, data_byte,
                   output ready);
endinterface

interface t0apc_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] byte_out;
   logic [2:0] status;
   logic [7:0] sw1;
   logic [7:0] sw2;
   logic       last;
   modport source (output valid, kind, byte_out, status, sw1, sw2, last, input ready);
   modport sink   (input valid, kind, byte_out, status, sw1, sw2, last, output ready);
endinterface

FILE: rtl/t0apc_core.sv
// Procedure byte state machine: holds the command state and turns one
// word into a burst of results. Depends on t0apc_pkg.
module t0apc_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  t0apc_pkg::item_type item,
   output t0apc_pkg::burst_type burst
);

   logic [1:0] phase_ff,      phase_in;
   logic [7:0] saved_ins_ff,  saved_ins_in;
   logic       write_dir_ff,  write_dir_in;
   logic [8:0] remaining_ff,  remaining_in;
   logic       moving_all_ff, moving_all_in;
   logic [7:0] saved_sw1_ff,  saved_sw1_in;

   logic [8:0] rem_dec;
   logic [7:0] b;

   assign b       = item.data_byte;
   assign rem_dec = remaining_ff - 9'd1;

   always_comb begin
      phase_in      = phase_ff;
      saved_ins_in  = saved_ins_ff;
      write_dir_in  = write_dir_ff;
      remaining_in  = remaining_ff;
      moving_all_in = moving_all_ff;
      saved_sw1_in  = saved_sw1_ff;
      burst         = '0;

      case (item.mode)
         t0apc_pkg::MODE_START: begin
            burst.count  = t0apc_pkg::CNT_W'(1);
            burst.kind   = t0apc_pkg::KIND_STATUS;
            phase_in     = t0apc_pkg::PH_IDLE;
            if (item.cla == t0apc_pkg::CLA_INVALID) begin
               burst.status = t0apc_pkg::ST_BAD_CMD;
            end else if (t0apc_pkg::is_sw_nibble(item.ins)) begin
               burst.status = t0apc_pkg::ST_BAD_INS;
            end else begin
               saved_ins_in  = item.ins;
               write_dir_in  = item.write_flag;
               remaining_in  = (item.p3 != 8'd0) ? {1'b0, item.p3}
                                                  : t0apc_pkg::FULL_LENGTH;
               moving_all_in = 1'b0;
               phase_in      = t0apc_pkg::PH_PROC;
               burst.count   = t0apc_pkg::CNT_W'(t0apc_pkg::BURST_MAX);
               burst.kind    = t0apc_pkg::KIND_TO_CARD;
               burst.bytes   = {item.p3, item.p2, item.p1, item.ins, item.cla};
            end
         end
         t0apc_pkg::MODE_CARD: begin
            case (phase_ff)
               t0apc_pkg::PH_PROC: begin
                  if (b == t0apc_pkg::PROC_NULL) begin
                     phase_in = phase_ff;
                  end else if (t0apc_pkg::is_sw_nibble(b)) begin
                     saved_sw1_in = b;
                     phase_in     = t0apc_pkg::PH_SW2;
                  end else if (b == saved_ins_ff) begin
                     moving_all_in = 1'b1;
                     if (remaining_ff != 9'd0) begin
                        phase_in = t0apc_pkg::PH_MOVE;
                     end
                  end else if (b == ~saved_ins_ff && remaining_ff != 9'd0) begin
                     moving_all_in = 1'b0;
                     phase_in      = t0apc_pkg::PH_MOVE;
                  end else begin
                     // Unknown byte, or a one-byte ack with nothing left.
                     phase_in     = t0apc_pkg::PH_IDLE;
                     burst.count  = t0apc_pkg::CNT_W'(1);
                     burst.kind   = t0apc_pkg::KIND_STATUS;
                     burst.status = t0apc_pkg::ST_BAD_PROC;
                  end
               end
               t0apc_pkg::PH_SW2: begin
                  phase_in     = t0apc_pkg::PH_IDLE;
                  burst.count  = t0apc_pkg::CNT_W'(1);
                  burst.kind   = t0apc_pkg::KIND_STATUS;
                  burst.status = t0apc_pkg::map_sw1(saved_sw1_ff);
                  burst.sw1    = saved_sw1_ff;
                  burst.sw2    = b;
               end
               t0apc_pkg::PH_MOVE: begin
                  if (!write_dir_ff) begin
                     remaining_in   = rem_dec;
                     burst.count    = t0apc_pkg::CNT_W'(1);
                     burst.kind     = t0apc_pkg::KIND_TO_HOST;
                     burst.bytes[0] = b;
                     if (!(moving_all_ff && rem_dec != 9'd0)) begin
                        phase_in = t0apc_pkg::PH_PROC;
                     end
                  end
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
         t0apc_pkg::MODE_HOST: begin
            if (phase_ff == t0apc_pkg::PH_MOVE && write_dir_ff) begin
               remaining_in   = rem_dec;
               burst.count    = t0apc_pkg::CNT_W'(1);
               burst.kind     = t0apc_pkg::KIND_TO_CARD;
               burst.bytes[0] = b;
               if (!(moving_all_ff && rem_dec != 9'd0)) begin
                  phase_in = t0apc_pkg::PH_PROC;
               end
            end
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= t0apc_pkg::PH_IDLE;
         saved_ins_ff  <= '0;
         write_dir_ff  <= 1'b0;
         remaining_ff  <= '0;
         moving_all_ff <= 1'b0;
         saved_sw1_ff  <= '0;
      end else if (step) begin
         phase_ff      <= phase_in;
         saved_ins_ff  <= saved_ins_in;
         write_dir_ff  <= write_dir_in;
         remaining_ff  <= remaining_in;
         moving_all_ff <= moving_all_in;
         saved_sw1_ff  <= saved_sw1_in;
      end
   end

   // The count never exceeds a full block of 256.
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      remaining_ff <= t0apc_pkg::FULL_LENGTH)
      else $error("remaining count out of range");

   // Data only moves while some count is left.
   a_move_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == t0apc_pkg::PH_MOVE |-> remaining_ff != 9'd0)
      else $error("move phase with nothing left");

   // An accepted header always leaves the block waiting for a procedure byte.
   a_header_phase: assert property (@(posedge clock) disable iff (reset)
      step && burst.count == t0apc_pkg::CNT_W'(t0apc_pkg::BURST_MAX)
      |=> phase_ff == t0apc_pkg::PH_PROC)
      else $error("header sent but not in procedure phase");

endmodule

FILE: rtl/t0apc_burst.sv
// Result register: holds one burst and hands it out one word per cycle while rsp_if is ready.
// Depends on t0apc_pkg and t0apc_rsp_if.
module t0apc_burst (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  t0apc_pkg::burst_type burst,
   output logic                 free,
   t0apc_rsp_if.source          rsp_if
);

   logic                           valid_ff, valid_in;
   logic [t0apc_pkg::CNT_W-1:0]    idx_ff,   idx_in;
   t0apc_pkg::burst_type           hold_ff;
   logic                           out_last;
   logic                           take;

   assign out_last = (idx_ff == hold_ff.count - t0apc_pkg::CNT_W'(1));
   assign take     = valid_ff && rsp_if.ready;
   assign free     = !valid_ff || (take && out_last);

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = '0;
      end else if (take) begin
         if (out_last) begin
            valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + t0apc_pkg::CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         hold_ff <= burst;
      end
   end

   assign rsp_if.valid    = valid_ff;
   assign rsp_if.kind     = hold_ff.kind;
   assign rsp_if.byte_out = hold_ff.bytes[idx_ff[2:0]];
   assign rsp_if.status   = hold_ff.status;
   assign rsp_if.sw1      = hold_ff.sw1;
   assign rsp_if.sw2      = hold_ff.sw2;
   assign rsp_if.last     = out_last;

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> idx_ff < hold_ff.count)
      else $error("burst index past its count");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      valid_ff && hold_ff.kind == t0apc_pkg::KIND_STATUS |-> out_last)
      else $error("status word not marked last");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load |-> free)
      else $error("burst loaded over a pending one");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      take && out_last && !load |=> !valid_ff)
      else $error("burst still valid after its last word");

endmodule

FILE: rtl/t0_apdu_procedure_controller_unit.sv
// Top level of the T=0 APDU procedure controller: input register, command
// state machine and result burst register. Depends on t0apc_pkg, t0apc_if,
// t0apc_core and t0apc_burst.
//
//   Channel   Direction   Handshake       Word
//   req_if    in          valid/ready     mode, cla, ins, p1, p2, p3, write_flag, data_byte
//   rsp_if    out         valid/ready     kind, byte_out, status, sw1, sw2, last
//
// A request word is captured in an input register and is processed once
// the result register is free or drains its last word. Words that give
// no result or one result flow at one word per cycle while rsp_if is ready.
// An accepted start command gives a five-word header burst, which holds
// the result register until all five words leave by the single output port.
// A stall on rsp_if holds the burst in place and back-pressures req_if
// once the input register is full. Synchronous reset clears the valid
// flags and the command state to idle.
module t0_apdu_procedure_controller_unit (
   input  logic        clock,
   input  logic        reset,
   t0apc_req_if.sink   req_if,
   t0apc_rsp_if.source rsp_if
);

   logic                 in_valid_ff, in_valid_in;
   t0apc_pkg::item_type  item_ff;
   t0apc_pkg::burst_type burst;
   logic                 free;
   logic                 step;
   logic                 accept;

   // The held word is processed once the result side can take its burst.
   assign step          = in_valid_ff && free;
   assign req_if.ready  = !in_valid_ff || step;
   assign accept        = req_if.valid && req_if.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= '{mode:       req_if.mode,
                      cla:        req_if.cla,
                      ins:        req_if.ins,
                      p1:         req_if.p1,
                      p2:         req_if.p2,
                      p3:         req_if.p3,
                      write_flag: req_if.write_flag,
                      data_byte:  req_if.data_byte};
      end
   end

   t0apc_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .item  (item_ff),
      .burst (burst)
   );

   // Words that cause no result only update the command state.
   t0apc_burst u_burst (
      .clock  (clock),
      .reset  (reset),
      .load   (step && burst.count != '0),
      .burst  (burst),
      .free   (free),
      .rsp_if (rsp_if)
   );

endmodule
